[src/rfpwd_pkg.sv]
// Package for the RF pulse width frame decoder.
// Holds payload and configuration types, register indexes, reset values and the house table.
// No dependencies.
package rfpwd_pkg;

	typedef struct packed {
		logic [15:0] low_width_us;
		logic [31:0] now_ms;
	} pulse_t;

	typedef struct packed {
		logic [3:0] house_index;
		logic [4:0] unit_number;
		logic [2:0] command_code;
		logic       is_repeat;
	} frame_t;

	typedef struct packed {
		logic [3:0] house_index;
		logic [4:0] unit_number;
		logic [2:0] command_code;
	} decoded_t;

	typedef struct packed {
		logic [15:0] start_min_us;
		logic [15:0] start_max_us;
		logic [15:0] one_min_us;
		logic [15:0] one_max_us;
		logic [15:0] zero_min_us;
		logic [15:0] zero_max_us;
		logic [15:0] repeat_window_ms;
	} cfg_t;

	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_START_MIN  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_START_MAX  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ONE_MIN    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ONE_MAX    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ZERO_MIN   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_ZERO_MAX   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_WIN = 3'd6;

	localparam logic [15:0] RST_START_MIN  = 16'd3500;
	localparam logic [15:0] RST_START_MAX  = 16'd5500;
	localparam logic [15:0] RST_ONE_MIN    = 16'd1200;
	localparam logic [15:0] RST_ONE_MAX    = 16'd2000;
	localparam logic [15:0] RST_ZERO_MIN   = 16'd300;
	localparam logic [15:0] RST_ZERO_MAX   = 16'd900;
	localparam logic [15:0] RST_REPEAT_WIN = 16'd500;

	localparam logic [2:0] CMD_ON  = 3'd2;
	localparam logic [2:0] CMD_OFF = 3'd3;
	localparam logic [2:0] CMD_DIM = 3'd4;
	localparam logic [2:0] CMD_BRT = 3'd5;

	// Reserved bit masks of the first and third bytes.
	localparam logic [7:0] BYTE1_RSV_MASK = 8'hD0;
	localparam logic [7:0] BYTE3_RSV_MASK = 8'hE0;

	// Transmitted house code to house index (0 is A).
	function automatic logic [3:0] house_of_code(input logic [3:0] code);
		logic [3:0] h;
		case (code)
			4'd0:    h = 4'd12;
			4'd1:    h = 4'd4;
			4'd2:    h = 4'd2;
			4'd3:    h = 4'd10;
			4'd4:    h = 4'd14;
			4'd5:    h = 4'd6;
			4'd6:    h = 4'd0;
			4'd7:    h = 4'd8;
			4'd8:    h = 4'd13;
			4'd9:    h = 4'd5;
			4'd10:   h = 4'd3;
			4'd11:   h = 4'd11;
			4'd12:   h = 4'd15;
			4'd13:   h = 4'd7;
			4'd14:   h = 4'd1;
			default: h = 4'd9;
		endcase
		return h;
	endfunction

endpackage

[src/rfpwd_if.sv]
// Valid/ready stream interfaces for pulse requests and decoded frame results.
// Depends on rfpwd_pkg for the payload types.
interface rfpwd_pulse_if import rfpwd_pkg::*; ();
	logic   valid;
	logic   ready;
	pulse_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rfpwd_frame_if import rfpwd_pkg::*; ();
	logic   valid;
	logic   ready;
	frame_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/rfpwd_cfg.sv]
// Configuration register file of the pulse width frame decoder.
// Depends on rfpwd_pkg for cfg_t, register indexes and reset values.
module rfpwd_cfg import rfpwd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_min_us     <= RST_START_MIN;
			cfg_q.start_max_us     <= RST_START_MAX;
			cfg_q.one_min_us       <= RST_ONE_MIN;
			cfg_q.one_max_us       <= RST_ONE_MAX;
			cfg_q.zero_min_us      <= RST_ZERO_MIN;
			cfg_q.zero_max_us      <= RST_ZERO_MAX;
			cfg_q.repeat_window_ms <= RST_REPEAT_WIN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_MIN:  cfg_q.start_min_us     <= cfg_data;
				REG_START_MAX:  cfg_q.start_max_us     <= cfg_data;
				REG_ONE_MIN:    cfg_q.one_min_us       <= cfg_data;
				REG_ONE_MAX:    cfg_q.one_max_us       <= cfg_data;
				REG_ZERO_MIN:   cfg_q.zero_min_us      <= cfg_data;
				REG_ZERO_MAX:   cfg_q.zero_max_us      <= cfg_data;
				REG_REPEAT_WIN: cfg_q.repeat_window_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/rfpwd_frame_decode.sv]
// Field decoder: turns the address byte and the function byte of a frame into
// house index, unit number and command code. Depends on rfpwd_pkg.
module rfpwd_frame_decode import rfpwd_pkg::*; (
	input  logic [7:0] byte1,
	input  logic [7:0] byte3,
	output decoded_t   dec
);

	logic [4:0] unit_raw;

	// Unit bits are scattered over both bytes.
	assign unit_raw = {byte3[7], byte3[6] | byte1[5], byte3[5] | byte3[1], byte3[4], byte3[3]};

	always_comb begin
		dec.house_index = house_of_code(byte1[3:0]);
		if (byte3[0]) begin
			dec.unit_number  = 5'd0;
			dec.command_code = byte3[3] ? CMD_DIM : CMD_BRT;
		end else begin
			dec.unit_number  = unit_raw + 5'd1;
			dec.command_code = byte3[2] ? CMD_OFF : CMD_ON;
		end
	end

endmodule

[src/rfpwd_core.sv]
// Decoder datapath: input register, pulse classification and frame state,
// and the result register. Depends on rfpwd_pkg, rfpwd_if and rfpwd_frame_decode.
module rfpwd_core import rfpwd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	rfpwd_pulse_if.sink   pulse,
	rfpwd_frame_if.source frame
);

	logic        valid_s1;
	pulse_t      pulse_s1;
	logic        advance;

	logic        collecting_q, collecting_n;
	logic [4:0]  bit_count_q, bit_count_n;
	logic [31:0] frame_bits_q, frame_bits_n;
	logic [31:0] last_start_q, last_start_n;
	decoded_t    last_q, last_n;

	logic        frame_valid_q;
	frame_t      frame_q;
	logic        res_load;
	logic        res_repeat;

	logic        is_start, is_one, is_zero, in_window;
	logic [31:0] elapsed;
	logic [31:0] bits_set;
	logic [4:0]  cmp_idx;
	decoded_t    dec;

	assign advance     = valid_s1 && (!frame_valid_q || frame.ready);
	assign pulse.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pulse.ready) begin
			valid_s1 <= pulse.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pulse.ready && pulse.valid) begin
			pulse_s1 <= pulse.data;
		end
	end

	assign is_start  = pulse_s1.low_width_us > cfg.start_min_us &&
			pulse_s1.low_width_us < cfg.start_max_us;
	assign is_one    = pulse_s1.low_width_us > cfg.one_min_us &&
			pulse_s1.low_width_us < cfg.one_max_us;
	assign is_zero   = pulse_s1.low_width_us >= cfg.zero_min_us &&
			pulse_s1.low_width_us <= cfg.zero_max_us;
	assign elapsed   = pulse_s1.now_ms - last_start_q;
	assign in_window = pulse_s1.now_ms > last_start_q &&
			elapsed < {16'd0, cfg.repeat_window_ms};

	// Bits of the second and fourth bytes are checked against the bit one byte back.
	assign cmp_idx  = bit_count_q - 5'd8;
	assign bits_set = frame_bits_q | ({31'd0, is_one} << bit_count_q);

	rfpwd_frame_decode u_decode (
		.byte1 (bits_set[7:0]),
		.byte3 (bits_set[23:16]),
		.dec   (dec)
	);

	always_comb begin
		collecting_n = collecting_q;
		bit_count_n  = bit_count_q;
		frame_bits_n = frame_bits_q;
		last_start_n = last_start_q;
		last_n       = last_q;
		res_load     = 1'b0;
		res_repeat   = 1'b0;
		if (!collecting_q) begin
			if (is_start) begin
				last_start_n = pulse_s1.now_ms;
				if (in_window) begin
					res_load   = 1'b1;
					res_repeat = 1'b1;
				end else begin
					collecting_n = 1'b1;
					bit_count_n  = 5'd0;
					frame_bits_n = 32'd0;
				end
			end
		end else if (!is_one && !is_zero) begin
			// A width outside both bit windows aborts and forgets the start time.
			last_start_n = 32'd0;
			collecting_n = 1'b0;
		end else if (bit_count_q[3] && frame_bits_q[cmp_idx] == is_one) begin
			collecting_n = 1'b0;
		end else begin
			frame_bits_n = bits_set;
			bit_count_n  = bit_count_q + 5'd1;
			if (bit_count_q == 5'd7 && |(bits_set[7:0] & BYTE1_RSV_MASK)) begin
				collecting_n = 1'b0;
			end else if (bit_count_q == 5'd23 && |(bits_set[23:16] & BYTE3_RSV_MASK)) begin
				collecting_n = 1'b0;
			end else if (bit_count_q == 5'd31) begin
				collecting_n = 1'b0;
				last_n       = dec;
				res_load     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			bit_count_q  <= 5'd0;
			frame_bits_q <= 32'd0;
			last_start_q <= 32'd0;
			last_q       <= '0;
		end else if (advance) begin
			collecting_q <= collecting_n;
			bit_count_q  <= bit_count_n;
			frame_bits_q <= frame_bits_n;
			last_start_q <= last_start_n;
			last_q       <= last_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
		end else begin
			frame_valid_q <= (advance && res_load) || (frame_valid_q && !frame.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_load) begin
			frame_q <= {last_n.house_index, last_n.unit_number, last_n.command_code, res_repeat};
		end
	end

	assign frame.valid = frame_valid_q;
	assign frame.data  = frame_q;

`ifndef SYNTHESIS
	a_fresh_cmd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid_q && !frame_q.is_repeat |->
			(frame_q.command_code == CMD_ON || frame_q.command_code == CMD_OFF ||
			 frame_q.command_code == CMD_DIM || frame_q.command_code == CMD_BRT))
		else $error("fresh frame result carries an undefined command");

	a_unit_matches_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid_q && !frame_q.is_repeat |->
			((frame_q.unit_number == 5'd0) ==
			 (frame_q.command_code == CMD_DIM || frame_q.command_code == CMD_BRT)))
		else $error("unit number does not agree with command");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> pulse.ready)
		else $error("input stage empty but request not accepted");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid_q && !frame.ready |=> frame_valid_q && $stable(frame_q))
		else $error("pending result lost or overwritten");
`endif

endmodule

[src/rf_pulse_width_frame_decoder.sv]
// Top level of the RF pulse width frame decoder: configuration registers and decoder core.
// Depends on rfpwd_pkg, rfpwd_if, rfpwd_cfg and rfpwd_core.
//
// Each pulse request carries one measured low pulse width and a millisecond
// timestamp. The block accepts one request per clock cycle; a request is
// registered, classified against the configured windows and, when it
// completes a 32-bit frame or is a start burst inside the repeat window,
// yields one result on the frame channel from a registered output. The input side
// stalls only while a finished result waits at the output register and the
// sink holds ready low. Configuration writes take effect on the cycle after
// the write enable and should be made while no request is in flight.
module rf_pulse_width_frame_decoder import rfpwd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	rfpwd_pulse_if.sink            pulse,
	rfpwd_frame_if.source          frame
);

	cfg_t cfg;

	rfpwd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rfpwd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.pulse  (pulse),
		.frame  (frame)
	);

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Testbench for rf_pulse_width_frame_decoder: random and directed pulse requests, scoreboarded.
// Depends on rfpwd_pkg, the rfpwd stream interfaces and the decoder top level.
module tb;
	import rfpwd_pkg::*;

	localparam int          CYCLE_LIMIT   = 400000;
	localparam int          SETTLE_CYCLES = 4;
	localparam int          RANDOM_ITEMS  = 950;
	localparam int          PHASES        = 6;
	localparam int          FRAME_PULSES  = 33;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

	localparam cfg_t RESET_WINDOWS = '{RST_START_MIN, RST_START_MAX, RST_ONE_MIN, RST_ONE_MAX,
		RST_ZERO_MIN, RST_ZERO_MAX, RST_REPEAT_WIN};

	// Transmitted house code to house index, entry 0 on the right.
	localparam logic [15:0][3:0] HOUSE_OF_CODE = {4'd9, 4'd1, 4'd7, 4'd15, 4'd11, 4'd3, 4'd5,
		4'd13, 4'd8, 4'd0, 4'd6, 4'd14, 4'd10, 4'd2, 4'd4, 4'd12};

	typedef enum {FAULT_NONE, FAULT_ERROR, FAULT_MATCH} fault_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	rfpwd_pulse_if pulse_ch ();
	rfpwd_frame_if frame_ch ();

	rf_pulse_width_frame_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pulse     (pulse_ch),
		.frame     (frame_ch)
	);

	// Decoder state as the testbench sees it.
	cfg_t        win           = RESET_WINDOWS;
	logic        collecting    = 1'b0;
	logic [4:0]  bit_count     = '0;
	logic [31:0] frame_bits    = '0;
	logic [31:0] last_start_ms = '0;
	logic [3:0]  last_house    = '0;
	logic [4:0]  last_unit     = '0;
	logic [2:0]  last_command  = '0;
	frame_t      pending_frames[$];

	logic [31:0] stamp_ms = 32'd1000;
	logic [31:0] burst_ms = '0;
	bit          steady   = 1'b0;
	int unsigned failures       = 0;
	int unsigned frames_seen    = 0;
	int unsigned repeats_seen   = 0;
	int unsigned pulses_sent    = 0;
	int unsigned settings_used  = 1;
	int unsigned cycle_count    = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) frame_ch.ready <= steady || ($urandom_range(99, 0) >= 30);

	function automatic bit is_one(input logic [15:0] w);
		return w > win.one_min_us && w < win.one_max_us;
	endfunction

	function automatic bit is_zero(input logic [15:0] w);
		return !is_one(w) && w >= win.zero_min_us && w <= win.zero_max_us;
	endfunction

	// Works out the frame result, if any, that one accepted pulse request causes.
	function automatic void decode_pulse(input pulse_t p);
		logic       b;
		logic [4:0] i;
		logic [7:0] b1;
		logic [7:0] b2;
		frame_t     f;
		if (!collecting) begin
			if (p.low_width_us > win.start_min_us && p.low_width_us < win.start_max_us) begin
				if (p.now_ms > last_start_ms &&
						p.now_ms - last_start_ms < {16'd0, win.repeat_window_ms}) begin
					last_start_ms = p.now_ms;
					f = '{last_house, last_unit, last_command, 1'b1};
					pending_frames.push_back(f);
					return;
				end
				last_start_ms = p.now_ms;
				collecting = 1'b1;
				bit_count = '0;
				frame_bits = '0;
			end
			return;
		end
		if (is_one(p.low_width_us)) begin
			b = 1'b1;
		end else if (is_zero(p.low_width_us)) begin
			b = 1'b0;
		end else begin
			last_start_ms = '0;
			collecting = 1'b0;
			return;
		end
		i = bit_count;
		// Bytes two and four must be the bitwise complement of bytes one and three.
		if ((i >= 5'd8 && i < 5'd16) || i >= 5'd24) begin
			if (frame_bits[i - 5'd8] == b) begin
				collecting = 1'b0;
				return;
			end
		end
		frame_bits[i] = b;
		bit_count = i + 5'd1;
		if ((i == 5'd7 && (frame_bits[7:0] & BYTE1_RSV_MASK) != 0) ||
				(i == 5'd23 && (frame_bits[23:16] & BYTE3_RSV_MASK) != 0)) begin
			collecting = 1'b0;
			return;
		end
		if (i != 5'd31)
			return;
		collecting = 1'b0;
		b1 = frame_bits[7:0];
		b2 = frame_bits[23:16];
		last_house = HOUSE_OF_CODE[b1[3:0]];
		if (b2[0]) begin
			last_unit = '0;
			last_command = b2[3] ? CMD_DIM : CMD_BRT;
		end else begin
			last_unit = {1'b0, b1[5], b2[1], b2[4], b2[3]} + 5'd1;
			last_command = b2[2] ? CMD_OFF : CMD_ON;
		end
		f = '{last_house, last_unit, last_command, 1'b0};
		pending_frames.push_back(f);
	endfunction

	always @(posedge clk) begin : scoreboard
		frame_t want;
		frame_t got;
		if (arst_n && frame_ch.valid && frame_ch.ready) begin
			got = frame_ch.data;
			if (pending_frames.size() == 0) begin
				$display("%0t: unexpected frame house %0d unit %0d command %0d repeat %0d",
					$time, got.house_index, got.unit_number, got.command_code, got.is_repeat);
				failures++;
			end else begin
				want = pending_frames.pop_front();
				frames_seen++;
				if (want.is_repeat)
					repeats_seen++;
				if (got.house_index !== want.house_index) begin
					$display("%0t: house_index expected %0d actual %0d",
						$time, want.house_index, got.house_index);
					failures++;
				end
				if (got.unit_number !== want.unit_number) begin
					$display("%0t: unit_number expected %0d actual %0d",
						$time, want.unit_number, got.unit_number);
					failures++;
				end
				if (got.command_code !== want.command_code) begin
					$display("%0t: command_code expected %0d actual %0d",
						$time, want.command_code, got.command_code);
					failures++;
				end
				if (got.is_repeat !== want.is_repeat) begin
					$display("%0t: is_repeat expected %0d actual %0d",
						$time, want.is_repeat, got.is_repeat);
					failures++;
				end
			end
		end
		if (arst_n && pulse_ch.valid && pulse_ch.ready)
			decode_pulse(pulse_ch.data);
	end

	function automatic logic [15:0] one_width();
		int lo;
		int hi;
		lo = win.one_min_us + 1;
		hi = win.one_max_us - 1;
		if (hi >= lo)
			return 16'($urandom_range(hi, lo));
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] zero_width();
		logic [15:0] w;
		for (int n = 0; n < 8; n++) begin
			w = 16'($urandom_range(win.zero_max_us, win.zero_min_us));
			if (is_zero(w))
				return w;
		end
		return win.zero_min_us;
	endfunction

	function automatic logic [15:0] error_width();
		logic [15:0] w;
		for (int n = 0; n < 16; n++) begin
			w = 16'($urandom);
			if (!is_one(w) && !is_zero(w))
				return w;
		end
		return 16'hFFFF;
	endfunction

	function automatic logic [15:0] start_width();
		int lo;
		int hi;
		lo = win.start_min_us + 1;
		hi = win.start_max_us - 1;
		if (hi >= lo)
			return 16'($urandom_range(hi, lo));
		return 16'($urandom);
	endfunction

	function automatic cfg_t random_windows(input bit high_start);
		cfg_t c;
		c.zero_min_us = 16'($urandom_range(400, 0));
		c.zero_max_us = c.zero_min_us + 16'($urandom_range(800, 50));
		c.one_min_us = c.zero_max_us + 16'($urandom_range(500, 1));
		c.one_max_us = c.one_min_us + 16'($urandom_range(2000, 3));
		if (high_start) begin
			c.start_min_us = 16'($urandom_range(40000, 33000));
			c.start_max_us = 16'hFFFF;
		end else begin
			c.start_min_us = c.one_max_us + 16'($urandom_range(1000, 0));
			c.start_max_us = c.start_min_us + 16'($urandom_range(20000, 3));
		end
		c.repeat_window_ms = 16'($urandom_range(2000, 1));
		return c;
	endfunction

	// One pulse request; returns at the edge where it is accepted.
	task automatic send_pulse(input logic [15:0] w, input logic [31:0] t);
		if (!steady && $urandom_range(99, 0) < 30) begin
			pulse_ch.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		pulse_ch.valid <= 1'b1;
		pulse_ch.data <= '{low_width_us: w, now_ms: t};
		@(posedge clk);
		while (!pulse_ch.ready) @(posedge clk);
		pulses_sent++;
	endtask

	task automatic send_start();
		burst_ms = stamp_ms;
		send_pulse(start_width(), stamp_ms);
	endtask

	// Start burst and 32 bits: byte one, its complement, byte three, its complement.
	task automatic send_frame(input logic [7:0] code_lo, input logic [7:0] cmd_hi,
			input fault_t fault, input int spot);
		logic [31:0] bits;
		logic [15:0] w;
		bits = {~cmd_hi, cmd_hi, ~code_lo, code_lo};
		if (fault == FAULT_MATCH)
			bits[spot] = ~bits[spot];
		stamp_ms = stamp_ms + win.repeat_window_ms + $urandom_range(2000, 0);
		send_start();
		for (int k = 0; k < 32; k++) begin
			if (fault == FAULT_ERROR && k == spot)
				w = error_width();
			else
				w = bits[k] ? one_width() : zero_width();
			stamp_ms = stamp_ms + $urandom_range(2, 0);
			send_pulse(w, stamp_ms);
		end
	endtask

	task automatic drain();
		pulse_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_START_MIN:  win.start_min_us = val;
			REG_START_MAX:  win.start_max_us = val;
			REG_ONE_MIN:    win.one_min_us = val;
			REG_ONE_MAX:    win.one_max_us = val;
			REG_ZERO_MIN:   win.zero_min_us = val;
			REG_ZERO_MAX:   win.zero_max_us = val;
			REG_REPEAT_WIN: win.repeat_window_ms = val;
			default: ;
		endcase
	endtask

	task automatic apply_windows(input cfg_t c);
		put_reg(REG_START_MIN, c.start_min_us);
		put_reg(REG_START_MAX, c.start_max_us);
		put_reg(REG_ONE_MIN, c.one_min_us);
		put_reg(REG_ONE_MAX, c.one_max_us);
		put_reg(REG_ZERO_MIN, c.zero_min_us);
		put_reg(REG_ZERO_MAX, c.zero_max_us);
		put_reg(REG_REPEAT_WIN, c.repeat_window_ms);
		// The spare index has no register behind it.
		put_reg(REG_SPARE, 16'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	task automatic test_ignored_pulses();
		send_pulse(16'h0000, 32'h0000_0000);
		send_pulse(16'hFFFF, 32'hFFFF_FFFF);
		send_pulse(RST_START_MIN, 32'd40);
		send_pulse(RST_START_MAX, 32'd60);
	endtask

	task automatic test_repeat_timing();
		// Nothing decoded yet, so the repeat carries the cleared stored command.
		send_pulse(16'd4500, 32'd120);
		// Same timestamp is not later than the last start: collection begins.
		send_pulse(16'd4500, 32'd120);
		// A start width while collecting is a bad bit and clears the start time.
		send_pulse(16'd4500, 32'd130);
		send_pulse(16'd4500, 32'd0);
		send_pulse(16'd1000, 32'd5);
		send_pulse(16'd4500, 32'd499);
		send_pulse(16'd4500, 32'd999);
		send_pulse(16'hFFFF, 32'd1000);
		send_pulse(16'd4500, 32'hFFFF_FFFF);
		send_pulse(16'h0000, 32'd3);
		stamp_ms = 32'd5000;
	endtask

	task automatic test_commands();
		send_frame(8'h00, 8'h00, FAULT_NONE, 0);
		send_frame(8'h2F, 8'h1E, FAULT_NONE, 0);
		send_frame(8'h26, 8'h19, FAULT_NONE, 0);
		send_frame(8'h09, 8'h01, FAULT_NONE, 0);
		stamp_ms = burst_ms + 32'd10;
		send_start();
	endtask

	task automatic test_frame_faults();
		send_frame(8'h10, 8'h00, FAULT_NONE, 0);
		send_frame(8'h03, 8'h80, FAULT_NONE, 0);
		send_frame(8'h05, 8'h04, FAULT_MATCH, 8);
		send_frame(8'h05, 8'h04, FAULT_MATCH, 31);
		send_frame(8'h07, 8'h02, FAULT_ERROR, 0);
		send_frame(8'h07, 8'h02, FAULT_ERROR, 31);
		send_frame(8'h2A, 8'h0A, FAULT_NONE, 0);
	endtask

	task automatic test_register_extremes();
		drain();
		apply_windows('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
		repeat (6) send_pulse(16'($urandom), $urandom);
		send_frame(8'h01, 8'h00, FAULT_NONE, 0);
		drain();
		apply_windows('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		repeat (6) send_pulse(16'($urandom), $urandom);
		send_frame(8'h01, 8'h00, FAULT_NONE, 0);
		drain();
		// Widest windows: every width is a one or a zero, every repeat is in range.
		apply_windows('{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF});
		send_frame(8'h2C, 8'h12, FAULT_NONE, 0);
		stamp_ms = burst_ms + 32'd5;
		send_start();
		repeat (12) send_pulse(16'($urandom), stamp_ms);
		drain();
	endtask

	task automatic run_traffic(input int target);
		int         done;
		int         pick;
		int         spot;
		logic [7:0] code_lo;
		logic [7:0] cmd_hi;
		done = 0;
		while (done < target) begin
			pick = $urandom_range(99, 0);
			code_lo = 8'($urandom) & ~BYTE1_RSV_MASK;
			cmd_hi = 8'($urandom) & ~BYTE3_RSV_MASK;
			if (pick < 55) begin
				send_frame(code_lo, cmd_hi, FAULT_NONE, 0);
				done += FRAME_PULSES;
				if ($urandom_range(1, 0)) begin
					for (int n = $urandom_range(3, 1); n > 0; n--) begin
						if (win.repeat_window_ms > 1)
							stamp_ms = burst_ms + $urandom_range(win.repeat_window_ms - 1, 1);
						else
							stamp_ms = burst_ms + $urandom_range(3, 0);
						send_start();
						done++;
					end
				end
			end else if (pick < 72) begin
				spot = $urandom_range(15, 0);
				case ($urandom_range(3, 0))
					0: send_frame(code_lo, cmd_hi, FAULT_ERROR, $urandom_range(31, 0));
					1: send_frame(code_lo, cmd_hi, FAULT_MATCH, spot < 8 ? spot + 8 : spot + 16);
					2: begin
						code_lo = 8'($urandom);
						if ((code_lo & BYTE1_RSV_MASK) == 0)
							code_lo = code_lo | 8'h80;
						send_frame(code_lo, cmd_hi, FAULT_NONE, 0);
					end
					default: begin
						cmd_hi = 8'($urandom);
						if ((cmd_hi & BYTE3_RSV_MASK) == 0)
							cmd_hi = cmd_hi | 8'h20;
						send_frame(code_lo, cmd_hi, FAULT_NONE, 0);
					end
				endcase
				done += FRAME_PULSES;
			end else if (pick < 82) begin
				// Stray start bursts at, inside or just past the repeat window, before the last start, or at random times.
				case ($urandom_range(3, 0))
					0: stamp_ms = burst_ms;
					1: stamp_ms = burst_ms + $urandom_range(win.repeat_window_ms + 2, 0);
					2: stamp_ms = burst_ms - $urandom_range(1000, 1);
					default: stamp_ms = $urandom;
				endcase
				send_start();
				done++;
			end else begin
				stamp_ms = $urandom;
				pick = $urandom_range(4, 1);
				repeat (pick) send_pulse(16'($urandom), stamp_ms);
				done += pick;
			end
		end
	endtask

	task automatic test_random_traffic();
		cfg_t c;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: c = RESET_WINDOWS;
				2: begin
					c = random_windows(1'b0);
					c.repeat_window_ms = 16'h0000;
				end
				3: begin
					c = random_windows(1'b1);
					c.repeat_window_ms = 16'hFFFF;
				end
				default: c = random_windows(phase == 4);
			endcase
			drain();
			apply_windows(c);
			steady = (phase == 1);
			run_traffic(RANDOM_ITEMS / PHASES);
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_START_MIN;
		cfg_data <= '0;
		pulse_ch.valid <= 1'b0;
		pulse_ch.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ignored_pulses();
		test_repeat_timing();
		test_commands();
		test_frame_faults();
		test_register_extremes();
		test_random_traffic();
		drain();

		$display("Checked %0d frame results (%0d repeats) from %0d pulse requests.",
			frames_seen, repeats_seen, pulses_sent);
		$display("Covered %0d window settings with bit errors, complement and reserved faults.",
			settings_used);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
